// ----- design/dfd_pkg.sv -----
package dfd_pkg;

    // Result kind, carried on tuser
    localparam logic [1:0] KIND_CELL   = 2'd0;
    localparam logic [1:0] KIND_ACCEPT = 2'd1;
    localparam logic [1:0] KIND_REJECT = 2'd2;

    // Status codes
    localparam logic [2:0] ERR_OK        = 3'd0;
    localparam logic [2:0] ERR_TOO_SHORT = 3'd1;
    localparam logic [2:0] ERR_BAD_START = 3'd2;
    localparam logic [2:0] ERR_BAD_SIZE  = 3'd3;
    localparam logic [2:0] ERR_BAD_END   = 3'd4;

    // Register map (index = paddr[2])
    localparam logic REG_START_MARKER = 1'b0;
    localparam logic REG_END_MARKER   = 1'b1;

    // Header is marker low, marker high, width, height; frame adds end byte
    localparam int unsigned HDR_LEN = 4;
    localparam int unsigned POS_W   = 17;
    localparam logic [POS_W-1:0] POS_MAX = '1;

    localparam int unsigned TDATA_W = 48;

    typedef struct packed {
        logic [1:0]  kind;
        logic [7:0]  cell_value;
        logic [15:0] cell_index;
        logic [7:0]  frame_width;
        logic [7:0]  frame_height;
        logic [2:0]  error_code;
    } dfd_item_t;

endpackage

// ----- design/display_frame_deframer_unit.sv -----
// Display frame deframer.
// Slave stream: one received byte per beat on s_tdata, s_tlast marking the
// last byte of the message. Master stream: one result beat per cell byte
// (tentative, only while the start marker matched) and one status beat per
// message, raised on the beat that carried s_tlast. m_tuser gives the kind:
// cell, frame accepted or frame rejected; the status code sits in m_tdata.
// Frame layout: marker low, marker high, width, height, width*height cells,
// end marker. Checks on the last byte, first failure wins: too short, bad
// start, bad size, bad end.
// Throughput: one beat per cycle in while the queue has room, one per cycle
// out while the receiver is ready. A result reaches m_tvalid through the small
// queue written by the front stage and the head register of the back stage.
// The queue decouples the two sides; when the receiver stalls the queue fills
// and s_tready drops only once it is full.
// Reset (aresetn low, synchronous) clears the message state, the queue and
// both marker registers. The APB port takes the start marker at 0x0 and
// the end marker at 0x4; write them only while the block is idle.
module display_frame_deframer_unit
    import dfd_pkg::*;
#(
    parameter int unsigned QUEUE_DEPTH = 4
) (
    input  logic               aclk,
    input  logic               aresetn,
    // APB configuration
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [2:0]         paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready,
    // input stream
    input  logic               s_tvalid,
    output logic               s_tready,
    input  logic [7:0]         s_tdata,   // [7:0] rx_byte
    input  logic               s_tlast,   // final_byte
    // result stream
    output logic               m_tvalid,
    input  logic               m_tready,
    output logic [TDATA_W-1:0] m_tdata,   // [7:0] cell_value, [23:8] cell_index,
                                          // [31:24] frame_width, [39:32] frame_height,
                                          // [42:40] error_code, [47:43] zero
    output logic [1:0]         m_tuser    // [1:0] kind
);

    logic [15:0] start_marker_reg;
    logic [7:0]  end_marker_reg;
    logic        cfg_wr;

    logic        q_full;
    logic        q_not_empty;
    logic        push;
    logic        pop;
    logic        beat_in;
    dfd_item_t   push_item;
    dfd_item_t   head_item;

    // configuration registers
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            start_marker_reg <= '0;
            end_marker_reg   <= '0;
        end else if (cfg_wr) begin
            unique case (paddr[2])
                REG_START_MARKER: start_marker_reg <= pwdata[15:0];
                REG_END_MARKER:   end_marker_reg   <= pwdata[7:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (paddr[2])
            REG_START_MARKER: prdata = {16'd0, start_marker_reg};
            REG_END_MARKER:   prdata = {24'd0, end_marker_reg};
            default:          prdata = '0;
        endcase
    end

    // input side: take a beat whenever the queue has room
    assign s_tready = !q_full;
    assign beat_in  = s_tvalid && s_tready;

    dfd_front u_front (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .beat_in      (beat_in),
        .rx_byte      (s_tdata),
        .final_byte   (s_tlast),
        .start_marker (start_marker_reg),
        .end_marker   (end_marker_reg),
        .push         (push),
        .push_item    (push_item)
    );

    dfd_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (push),
        .push_item (push_item),
        .pop       (pop),
        .full      (q_full),
        .not_empty (q_not_empty),
        .head_item (head_item)
    );

    dfd_back u_back (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .q_not_empty (q_not_empty),
        .q_item      (head_item),
        .pop         (pop),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .m_tuser     (m_tuser)
    );

endmodule

// ----- design/dfd_front.sv -----
module dfd_front
    import dfd_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        beat_in,
    input  logic [7:0]  rx_byte,
    input  logic        final_byte,
    input  logic [15:0] start_marker,
    input  logic [7:0]  end_marker,
    output logic        push,
    output dfd_item_t   push_item
);

    logic [POS_W-1:0] pos_reg, pos_next;
    logic [7:0]       marker_lo_reg, marker_lo_next;
    logic             start_match_reg, start_match_next;
    logic [7:0]       width_reg, width_next;
    logic [7:0]       height_reg, height_next;
    logic [15:0]      expected_reg, expected_next;

    logic [POS_W-1:0] cell_idx;
    logic [POS_W-1:0] full_pos;
    logic [2:0]       err;

    assign cell_idx = pos_reg - POS_W'(HDR_LEN);
    // final byte sits at position 4 + cells in a well-sized frame
    assign full_pos = POS_W'(expected_reg) + POS_W'(HDR_LEN);

    always_comb begin
        priority if (pos_reg < POS_W'(HDR_LEN)) begin
            err = ERR_TOO_SHORT;
        end else if (!start_match_reg) begin
            err = ERR_BAD_START;
        end else if (pos_reg != full_pos) begin
            err = ERR_BAD_SIZE;
        end else if (rx_byte != end_marker) begin
            err = ERR_BAD_END;
        end else begin
            err = ERR_OK;
        end
    end

    always_comb begin
        pos_next         = pos_reg;
        marker_lo_next   = marker_lo_reg;
        start_match_next = start_match_reg;
        width_next       = width_reg;
        height_next      = height_reg;
        expected_next    = expected_reg;
        push             = 1'b0;
        push_item.kind         = KIND_CELL;
        push_item.cell_value   = rx_byte;
        push_item.cell_index   = cell_idx[15:0];
        push_item.frame_width  = width_reg;
        push_item.frame_height = height_reg;
        push_item.error_code   = ERR_OK;

        if (beat_in) begin
            if (final_byte) begin
                push                 = 1'b1;
                push_item.kind       = (err == ERR_OK) ? KIND_ACCEPT : KIND_REJECT;
                push_item.cell_value = '0;
                push_item.cell_index = '0;
                push_item.error_code = err;
                pos_next         = '0;
                marker_lo_next   = '0;
                start_match_next = 1'b0;
                width_next       = '0;
                height_next      = '0;
                expected_next    = '0;
            end else begin
                if (pos_reg != POS_MAX) begin
                    pos_next = pos_reg + 1'b1;
                end
                priority if (pos_reg == POS_W'(0)) begin
                    marker_lo_next = rx_byte;
                end else if (pos_reg == POS_W'(1)) begin
                    start_match_next = ({rx_byte, marker_lo_reg} == start_marker);
                end else if (pos_reg == POS_W'(2)) begin
                    width_next = rx_byte;
                end else if (pos_reg == POS_W'(3)) begin
                    height_next   = rx_byte;
                    expected_next = width_reg * rx_byte;
                end else begin
                    push = start_match_reg && (cell_idx < POS_W'(expected_reg));
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pos_reg         <= '0;
            marker_lo_reg   <= '0;
            start_match_reg <= 1'b0;
            width_reg       <= '0;
            height_reg      <= '0;
            expected_reg    <= '0;
        end else begin
            pos_reg         <= pos_next;
            marker_lo_reg   <= marker_lo_next;
            start_match_reg <= start_match_next;
            width_reg       <= width_next;
            height_reg      <= height_next;
            expected_reg    <= expected_next;
        end
    end

endmodule

// ----- design/dfd_queue.sv -----
module dfd_queue
    import dfd_pkg::*;
#(
    parameter int unsigned DEPTH = 4
) (
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      push,
    input  dfd_item_t push_item,
    input  logic      pop,
    output logic      full,
    output logic      not_empty,
    output dfd_item_t head_item
);

    localparam int unsigned PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CW = $clog2(DEPTH + 1);

    dfd_item_t      slot_reg [DEPTH];
    logic [PW-1:0]  wr_ptr_reg, wr_ptr_next;
    logic [PW-1:0]  rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0]  count_reg, count_next;

    assign full      = (count_reg == CW'(DEPTH));
    assign not_empty = (count_reg != '0);
    assign head_item = slot_reg[rd_ptr_reg];

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push) begin
            wr_ptr_next = (wr_ptr_reg == PW'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop) begin
            rd_ptr_next = (rd_ptr_reg == PW'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop) begin
            count_next = count_reg + 1'b1;
        end else if (pop && !push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            slot_reg[wr_ptr_reg] <= push_item;
        end
    end

endmodule

// ----- design/dfd_back.sv -----
module dfd_back
    import dfd_pkg::*;
(
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               q_not_empty,
    input  dfd_item_t          q_item,
    output logic               pop,
    output logic               m_tvalid,
    input  logic               m_tready,
    output logic [TDATA_W-1:0] m_tdata,
    output logic [1:0]         m_tuser
);

    logic      valid_reg;
    dfd_item_t out_reg;

    assign pop = q_not_empty && (!valid_reg || m_tready);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (!valid_reg || m_tready) begin
            valid_reg <= q_not_empty;
        end
    end

    always_ff @(posedge aclk) begin
        if (pop) begin
            out_reg <= q_item;
        end
    end

    assign m_tvalid = valid_reg;
    assign m_tuser  = out_reg.kind;
    assign m_tdata  = {5'd0, out_reg.error_code, out_reg.frame_height,
                       out_reg.frame_width, out_reg.cell_index, out_reg.cell_value};

endmodule

// ----- design/dfd_checker.sv -----
module dfd_checker
    import dfd_pkg::*;
(
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               pready,
    input  logic               m_tvalid,
    input  logic               m_tready,
    input  logic [TDATA_W-1:0] m_tdata,
    input  logic [1:0]         m_tuser
);

    // a stalled result beat is held
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid)
        else $error("result beat dropped while stalled");

    // nothing comes out in the cycle after reset
    a_reset: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("result valid straight after reset");

    // accepted frame always carries a clean status, rejected never does
    a_status: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser != KIND_CELL |->
            ((m_tuser == KIND_ACCEPT) == (m_tdata[42:40] == ERR_OK)) &&
            m_tdata[23:0] == 24'd0)
        else $error("status beat inconsistent");

    // cell beats carry no status, and kind code three never appears
    a_cell: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (m_tuser == KIND_CELL || m_tuser == KIND_ACCEPT ||
                      m_tuser == KIND_REJECT) &&
                     (m_tuser != KIND_CELL || m_tdata[42:40] == ERR_OK) &&
                     m_tdata[47:43] == 5'd0 && pready)
        else $error("cell beat malformed");

endmodule

bind display_frame_deframer_unit dfd_checker u_dfd_checker (.*);

// ----- verif/tb_top.sv -----
module tb_top
    import dfd_pkg::*;
;
    timeunit 1ns;
    timeprecision 1ps;

    // Cycles with no beat on either side before the run is abandoned. The
    // longest quiet stretch in a correct run is the receiver hold-off plus a
    // sender gap and a register write, so this limit is several times over.
    localparam int unsigned IDLE_LIMIT  = 2000;
    localparam int unsigned HOLD_CYCLES = 250;
    // Result reaches m_tvalid through the queue and the output register; allow a margin
    localparam int unsigned SETTLE_CYCLES = 8;
    localparam int unsigned RANDOM_BEATS  = 1700;

    // ------------------------------------------------------------------
    // Frame parser mirror: tracks the message state, holds the results
    // still owed by the block and checks each one as it leaves.
    // ------------------------------------------------------------------
    class frame_parse_tracker;
        bit [15:0]  start_mk;
        bit [7:0]   end_mk;
        bit [16:0]  pos;
        bit [7:0]   low_b;
        bit         matched;
        bit [7:0]   wid;
        bit [7:0]   hgt;
        bit [15:0]  cells_due;
        dfd_item_t  due_results[$];
        int unsigned error_total;

        function void flag_error(string what);
            error_total++;
            if (error_total <= 10) $display("%s", what);
        endfunction

        function void clear_message();
            pos       = '0;
            low_b     = '0;
            matched   = 1'b0;
            wid       = '0;
            hgt       = '0;
            cells_due = '0;
        endfunction

        // One accepted input beat
        function void take_rx_byte(bit [7:0] b, bit last);
            dfd_item_t   r;
            int unsigned len;
            int unsigned idx;
            bit [16:0]   old;
            if (last) begin
                len = pos + 32'd1;
                r   = '0;
                if (len < HDR_LEN + 1)
                    r.error_code = ERR_TOO_SHORT;
                else if (!matched)
                    r.error_code = ERR_BAD_START;
                else if (len != HDR_LEN + 1 + cells_due)
                    r.error_code = ERR_BAD_SIZE;
                else if (b != end_mk)
                    r.error_code = ERR_BAD_END;
                else
                    r.error_code = ERR_OK;
                r.kind         = (r.error_code == ERR_OK) ? KIND_ACCEPT : KIND_REJECT;
                r.frame_width  = wid;
                r.frame_height = hgt;
                due_results.insert(due_results.size(), r);
                clear_message();
                return;
            end
            old = pos;
            if (pos != POS_MAX) pos = pos + 1'b1;
            case (old)
                17'd0: low_b = b;
                17'd1: matched = ({b, low_b} == start_mk);
                17'd2: wid = b;
                17'd3: begin
                    hgt       = b;
                    cells_due = wid * hgt;
                end
                default: begin
                    idx = old - HDR_LEN;
                    if (matched && idx < cells_due) begin
                        r              = '0;
                        r.kind         = KIND_CELL;
                        r.cell_value   = b;
                        r.cell_index   = idx[15:0];
                        r.frame_width  = wid;
                        r.frame_height = hgt;
                        r.error_code   = ERR_OK;
                        due_results.insert(due_results.size(), r);
                    end
                end
            endcase
        endfunction

        // One accepted result beat
        function void match_result(logic [1:0] kind, logic [TDATA_W-1:0] data);
            dfd_item_t want;
            dfd_item_t got;
            got = '{kind: kind, cell_value: data[7:0], cell_index: data[23:8],
                    frame_width: data[31:24], frame_height: data[39:32],
                    error_code: data[42:40]};
            if (due_results.size() == 0) begin
                flag_error($sformatf("unexpected result: kind %0d tdata %h", kind, data));
                return;
            end
            want = due_results.pop_front();
            if (got !== want)
                flag_error($sformatf({"result mismatch: exp kind %0d val %h idx %0d w %0d",
                                      " h %0d err %0d / got kind %0d val %h idx %0d w %0d",
                                      " h %0d err %0d"},
                                     want.kind, want.cell_value, want.cell_index,
                                     want.frame_width, want.frame_height, want.error_code,
                                     got.kind, got.cell_value, got.cell_index,
                                     got.frame_width, got.frame_height, got.error_code));
        endfunction
    endclass

    logic               aclk;
    logic               aresetn;
    logic               psel;
    logic               penable;
    logic               pwrite;
    logic [2:0]         paddr;
    logic [31:0]        pwdata;
    logic [31:0]        prdata;
    logic               pready;
    logic               s_tvalid;
    logic               s_tready;
    logic [7:0]         s_tdata;    // [7:0] rx_byte
    logic               s_tlast;    // final_byte
    logic               m_tvalid;
    logic               m_tready;
    logic [TDATA_W-1:0] m_tdata;    // [7:0] cell_value, [23:8] cell_index,
                                    // [31:24] frame_width, [39:32] frame_height,
                                    // [42:40] error_code, [47:43] zero
    logic [1:0]         m_tuser;    // [1:0] kind

    frame_parse_tracker tracker = new();

    bit [7:0]    msg[$];            // bytes of the next message to send
    int unsigned burst_left  = 0;
    int unsigned accepted_in = 0;   // input beats accepted so far
    int unsigned idle_cycles = 0;

    display_frame_deframer_unit i_dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    initial begin
        aclk = 1'b0;
        forever #1 aclk = ~aclk;
    end

    // ------------------------------------------------------------------
    // Monitor: both handshakes sampled at the rising edge in one process,
    // input noted before the output is checked. Also the watchdog.
    // ------------------------------------------------------------------
    always @(posedge aclk) begin
        if (aresetn) begin
            idle_cycles++;
            if (s_tvalid && s_tready) begin
                tracker.take_rx_byte(s_tdata, s_tlast);
                accepted_in++;
                idle_cycles = 0;
            end
            if (m_tvalid && m_tready) begin
                tracker.match_result(m_tuser, m_tdata);
                idle_cycles = 0;
            end
            if (idle_cycles >= IDLE_LIMIT) begin
                $display("display_frame_deframer_unit test failed");
                $finish;
            end
        end
    end

    // ------------------------------------------------------------------
    // Receiver: repeating pattern, always ready in its first part and ready
    // two times in three in the rest. At 500 input beats and every 900 after,
    // it holds off for a long stretch so the internal queue fills and s_tready drops.
    // ------------------------------------------------------------------
    initial begin
        int unsigned hold_left;
        int unsigned next_hold_at;
        int unsigned rx_phase;
        hold_left    = 0;
        next_hold_at = 500;
        rx_phase     = 0;
        m_tready     = 1'b0;
        forever begin
            @(negedge aclk);
            if (hold_left != 0) begin
                hold_left--;
                m_tready <= 1'b0;
            end else if (accepted_in >= next_hold_at) begin
                hold_left    = HOLD_CYCLES - 1;
                next_hold_at = next_hold_at + 900;
                m_tready <= 1'b0;
            end else begin
                rx_phase = (rx_phase + 1) % 80;
                m_tready <= (rx_phase < 24) || ($urandom_range(0, 2) != 0);
            end
        end
    end

    // ------------------------------------------------------------------
    // Sender side
    // ------------------------------------------------------------------

    // Offer one beat and wait for it to be taken. Bursts of 1..24 beats,
    // back to back or separated by an idle gap; tvalid stays high within a burst.
    task automatic send_beat(input bit [7:0] b, input bit last);
        int unsigned gap;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 24);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
            if (gap != 0) begin
                @(negedge aclk);
                s_tvalid <= 1'b0;
                repeat (gap - 1) @(negedge aclk);
            end
        end
        @(negedge aclk);
        s_tvalid <= 1'b1;
        s_tdata  <= b;
        s_tlast  <= last;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        burst_left--;
    endtask

    task automatic send_message();
        foreach (msg[i]) send_beat(msg[i], i == msg.size() - 1);
    endtask

    // Frame under the current markers. size_delta shifts the cell count
    // (negative truncates, positive adds trailing bytes).
    task automatic build_frame(input int unsigned w, input int unsigned h,
                               input bit ok_start, input bit ok_end, input int size_delta);
        bit [15:0] mk;
        bit [7:0]  eb;
        int        n;
        mk = tracker.start_mk;
        if (!ok_start) mk = mk ^ (16'd1 << $urandom_range(0, 15));
        eb = tracker.end_mk;
        if (!ok_end) eb = eb ^ 8'($urandom_range(1, 255));
        n = int'(w * h) + size_delta;
        if (n < 0) n = 0;
        msg.delete();
        msg.insert(msg.size(), mk[7:0]);
        msg.insert(msg.size(), mk[15:8]);
        msg.insert(msg.size(), w[7:0]);
        msg.insert(msg.size(), h[7:0]);
        repeat (n) msg.insert(msg.size(), 8'($urandom_range(0, 255)));
        msg.insert(msg.size(), eb);
    endtask

    // ------------------------------------------------------------------
    // APB
    // ------------------------------------------------------------------
    task automatic apb_write(input logic [2:0] addr, input logic [31:0] data);
        @(negedge aclk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= data;
        @(negedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        while (!pready) @(posedge aclk);
        @(negedge aclk);
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    task automatic apb_read(input logic [2:0] addr, output logic [31:0] data);
        @(negedge aclk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        paddr   <= addr;
        @(negedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        while (!pready) @(posedge aclk);
        data = prdata;
        @(negedge aclk);
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    // Both markers written with junk in the unused upper bits, then read back
    task automatic configure(input bit [15:0] smk, input bit [7:0] emk);
        logic [31:0] rd;
        apb_write({REG_START_MARKER, 2'b00}, {16'($urandom), smk});
        apb_write({REG_END_MARKER, 2'b00}, {24'($urandom), emk});
        tracker.start_mk = smk;
        tracker.end_mk   = emk;
        apb_read({REG_START_MARKER, 2'b00}, rd);
        if (rd !== {16'h0, smk})
            tracker.flag_error($sformatf("start marker readback: exp %h got %h", smk, rd));
        apb_read({REG_END_MARKER, 2'b00}, rd);
        if (rd !== {24'h0, emk})
            tracker.flag_error($sformatf("end marker readback: exp %h got %h", emk, rd));
    endtask

    // Drop tvalid, wait for every owed result, then let the pipe settle
    task automatic wait_idle();
        @(negedge aclk);
        s_tvalid <= 1'b0;
        burst_left = 0;
        while (tracker.due_results.size() != 0) @(negedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    // ------------------------------------------------------------------
    // Stimulus
    // ------------------------------------------------------------------
    initial begin
        int unsigned sent;
        int unsigned phase_beats;
        int unsigned setting;
        int unsigned sel;
        int unsigned w;
        int unsigned h;
        int unsigned keep;

        aresetn  = 1'b0;
        psel     = 1'b0;
        penable  = 1'b0;
        pwrite   = 1'b0;
        paddr    = '0;
        pwdata   = '0;
        s_tvalid = 1'b0;
        s_tdata  = '0;
        s_tlast  = 1'b0;
        repeat (6) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // Markers still at their reset value of zero: empty 0x0 frame
        build_frame(0, 0, 1'b1, 1'b1, 0);
        send_message();
        wait_idle();

        // -------- directed --------
        configure(16'hA55A, 8'h7E);
        build_frame(1, 1, 1'b1, 1'b1, 0);       // good frame, one cell
        send_message();
        build_frame(1, 1, 1'b1, 1'b1, 1);       // byte past the cells: bad size
        send_message();
        build_frame(1, 1, 1'b0, 1'b1, 0);       // marker mismatch: no cells, bad start
        send_message();
        build_frame(1, 1, 1'b1, 1'b0, 0);       // wrong end byte
        send_message();
        // four bytes: too short, width stored but height arrived as last byte
        build_frame(3, 2, 1'b1, 1'b1, 0);
        while (msg.size() > 4) void'(msg.pop_back());
        send_message();

        // -------- random --------
        // Mostly well-formed frames with random content, the rest broken
        // frames, truncated headers and noise. Markers change every ~350 beats.
        sent        = 0;
        phase_beats = 0;
        setting     = 0;
        while (sent < RANDOM_BEATS) begin
            if (phase_beats >= 350) begin
                wait_idle();
                case (setting)
                    0:       configure(16'hFFFF, 8'hFF);
                    1:       configure(16'h0000, 8'h00);
                    default: configure(16'($urandom), 8'($urandom));
                endcase
                setting++;
                phase_beats = 0;
            end
            if ($urandom_range(0, 15) == 0) begin
                w = $urandom_range(0, 16);
                h = $urandom_range(0, 16);
            end else begin
                w = $urandom_range(0, 6);
                h = $urandom_range(0, 6);
            end
            sel = $urandom_range(0, 99);
            if (sel < 55) begin
                build_frame(w, h, 1'b1, 1'b1, 0);
            end else if (sel < 65) begin
                build_frame(w, h, 1'b1, 1'b0, 0);
            end else if (sel < 75) begin
                build_frame(w, h, 1'b1, 1'b1,
                            $urandom_range(0, 1) ? int'($urandom_range(1, 3))
                                                 : -int'($urandom_range(1, 3)));
            end else if (sel < 83) begin
                build_frame(w, h, 1'b0, 1'b1, 0);
            end else if (sel < 91) begin
                build_frame(w, h, 1'b1, 1'b1, 0);
                keep = $urandom_range(1, 4);
                while (msg.size() > keep) void'(msg.pop_back());
            end else begin
                msg.delete();
                repeat ($urandom_range(5, 40))
                    msg.insert(msg.size(), 8'($urandom_range(0, 255)));
            end
            send_message();
            sent        = sent + msg.size();
            phase_beats = phase_beats + msg.size();
        end
        wait_idle();

        // Anything still owed is a failure
        while (tracker.due_results.size() != 0) begin
            tracker.flag_error($sformatf("missing result: kind %0d idx %0d",
                                         tracker.due_results[0].kind,
                                         tracker.due_results[0].cell_index));
            void'(tracker.due_results.pop_front());
        end

        if (tracker.error_total == 0) begin
            $display("display_frame_deframer_unit test passed");
        end else begin
            $display("display_frame_deframer_unit test failed");
        end
        $finish;
    end

endmodule

// ----- display_frame_deframer_unit.f -----
design/dfd_pkg.sv
design/dfd_front.sv
design/dfd_queue.sv
design/dfd_back.sv
design/display_frame_deframer_unit.sv
design/dfd_checker.sv
verif/tb_top.sv
